// ----- rtl/difference_penalty_accumulator_unit_macros.svh -----
// assertion helpers shared by the rtl; the using module provides clk and rst
`ifndef DIFFERENCE_PENALTY_ACCUMULATOR_UNIT_MACROS_SVH
`define DIFFERENCE_PENALTY_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define DPA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dpa assertion failed");

// next-cycle implication
`define DPA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpa assertion failed");

`endif

// ----- rtl/dpa_pkg.sv -----
`timescale 1ns / 1ps

package dpa_pkg;

  localparam int MAX_ORDER = 4;
  localparam int MAX_LEN   = 64;

  localparam int COEF_W = 24;
  localparam int K_W    = 3;
  localparam int LEN_W  = 7;
  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int BANK_W = $clog2(MAX_ORDER);
  localparam int TAP_W  = 4;
  localparam int DIFF_W = COEF_W + 5;
  localparam int MAG_W  = DIFF_W - 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = 64;
  localparam int CFG_W  = 7;
  localparam int CIDX_W = 3;

  localparam logic [SUM_W-1:0] SAT_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  // register indexes
  localparam logic [CIDX_W-1:0] REG_DIMENSIONS    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_DIFF_ORDER    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ROW_COUNT     = 3'd2;
  localparam logic [CIDX_W-1:0] REG_COLUMN_COUNT  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_EQUAL_WEIGHTS = 3'd4;

  localparam logic [1:0] DIM_GRID = 2'd2;

  typedef logic [MAX_ORDER:0][COEF_W-1:0]   hist_t;
  typedef logic [MAX_ORDER-1:0][COEF_W-1:0] bank_data_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [BANK_W-1:0] bank;
    logic [IDX_W-1:0]  addr;
    logic [COEF_W-1:0] data;
  } store_req_t;

  typedef struct packed {
    logic row_ok;
    logic col_ok;
    logic last;
    logic bad;
  } item_ctrl_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    if (v == '0) return LEN_W'(1);
    if (v > LEN_W'(MAX_LEN)) return LEN_W'(MAX_LEN);
    return v;
  endfunction

  // (-1)^m * C(k, m)
  function automatic logic signed [TAP_W-1:0] tap_coef(input logic [K_W-1:0] k,
                                                      input logic [K_W-1:0] m);
    logic signed [TAP_W-1:0] t;
    t = '0;
    case (k)
      3'd0: if (m == 3'd0) t = 4'sd1;
      3'd1: case (m)
        3'd0: t = 4'sd1;
        3'd1: t = -4'sd1;
        default: t = '0;
      endcase
      3'd2: case (m)
        3'd0: t = 4'sd1;
        3'd1: t = -4'sd2;
        3'd2: t = 4'sd1;
        default: t = '0;
      endcase
      3'd3: case (m)
        3'd0: t = 4'sd1;
        3'd1: t = -4'sd3;
        3'd2: t = 4'sd3;
        3'd3: t = -4'sd1;
        default: t = '0;
      endcase
      3'd4: case (m)
        3'd0: t = 4'sd1;
        3'd1: t = -4'sd4;
        3'd2: t = 4'sd6;
        3'd3: t = -4'sd4;
        3'd4: t = 4'sd1;
        default: t = '0;
      endcase
      default: t = '0;
    endcase
    return t;
  endfunction

  // magnitude of the order-k difference; h[0] is the newest value
  function automatic logic [MAG_W-1:0] diff_mag(input logic [K_W-1:0] k, input hist_t h);
    logic signed [DIFF_W-1:0] acc;
    logic signed [DIFF_W-1:0] t;
    logic signed [DIFF_W-1:0] v;
    acc = '0;
    for (int m = 0; m <= MAX_ORDER; m++) begin
      if (K_W'(m) <= k) begin
        t = DIFF_W'(tap_coef(k, K_W'(m)));
        v = DIFF_W'($signed(h[m]));
        acc = acc + DIFF_W'(t * v);
      end
    end
    if (acc[DIFF_W-1]) acc = -acc;
    return acc[MAG_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[SUM_W] || s[SUM_W-1]) return SAT_MAX;
    return s[SUM_W-1:0];
  endfunction

endpackage

// ----- rtl/dpa_line_store.sv -----
`timescale 1ns / 1ps

// one bank per column slot, read-first, registered read
module dpa_line_store (
  input  logic                clk,
  input  dpa_pkg::store_req_t req,
  output dpa_pkg::bank_data_t rd_data
);

  for (genvar b = 0; b < dpa_pkg::MAX_ORDER; b++) begin : g_bank
    logic [dpa_pkg::COEF_W-1:0] mem [dpa_pkg::MAX_LEN];
    logic [dpa_pkg::COEF_W-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (req.rd_en) rd_q <= mem[req.addr];
      if (req.wr_en && req.bank == dpa_pkg::BANK_W'(b)) mem[req.addr] <= req.data;
    end

    assign rd_data[b] = rd_q;
  end

endmodule

// ----- rtl/difference_penalty_accumulator_unit.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// coef      in         coef_valid / coef_ready    coef_value
// result    out        result_valid / result_ready penalty_rows, penalty_cols, status
// cfg       in         cfg_write                  cfg_index, cfg_data
//
// one coefficient per cycle while coef_ready is high, through the input and store read,
// difference, square, accumulate and result registers
// rst clears configuration to defaults, indices, taps and sums; no store clear
// input stalls only while both result slots are full and a last beat reaches the sums
module difference_penalty_accumulator_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dpa_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [dpa_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              coef_valid,
  output logic                              coef_ready,
  input  logic signed [dpa_pkg::COEF_W-1:0] coef_value,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [dpa_pkg::SUM_W-1:0]  penalty_rows,
  output logic signed [dpa_pkg::SUM_W-1:0]  penalty_cols,
  output logic                              status
);

  `include "difference_penalty_accumulator_unit_macros.svh"

  // configuration
  logic [1:0]                  dimensions;
  logic [dpa_pkg::K_W-1:0]     diff_order;
  logic [dpa_pkg::LEN_W-1:0]   row_count;
  logic [dpa_pkg::LEN_W-1:0]   column_count;
  logic                        equal_weights;
  logic                        cfg_restart;

  // stream position
  logic [dpa_pkg::IDX_W-1:0]   row_index;
  logic [dpa_pkg::IDX_W-1:0]   column_index;
  logic [dpa_pkg::MAX_ORDER-1:0][dpa_pkg::COEF_W-1:0] row_taps;

  logic                        grid;
  logic [dpa_pkg::K_W-1:0]     k;
  logic [dpa_pkg::LEN_W-1:0]   nr;
  logic [dpa_pkg::LEN_W-1:0]   nc;
  logic [dpa_pkg::IDX_W-1:0]   r;
  logic [dpa_pkg::IDX_W-1:0]   c;
  logic                        row_last;
  logic                        col_last;
  logic                        in_acc;
  logic                        adv;
  logic                        out_free;
  dpa_pkg::item_ctrl_t         ctrl0;

  dpa_pkg::store_req_t         store_req;
  dpa_pkg::bank_data_t         store_rd;

  // stage 1
  logic                        s1_valid;
  dpa_pkg::item_ctrl_t         s1_ctrl;
  logic [dpa_pkg::K_W-1:0]     s1_k;
  logic [dpa_pkg::BANK_W-1:0]  s1_bank;
  dpa_pkg::hist_t              s1_hist;
  dpa_pkg::hist_t              col_hist;

  // stage 2
  logic                        s2_valid;
  dpa_pkg::item_ctrl_t         s2_ctrl;
  logic [dpa_pkg::MAG_W-1:0]   s2_mag_row;
  logic [dpa_pkg::MAG_W-1:0]   s2_mag_col;

  // stage 3
  logic                        s3_valid;
  dpa_pkg::item_ctrl_t         s3_ctrl;
  logic [dpa_pkg::SQ_W-1:0]    s3_sq_row;
  logic [dpa_pkg::SQ_W-1:0]    s3_sq_col;

  // accumulation and finished sums
  logic [dpa_pkg::SUM_W-1:0]   row_sum;
  logic [dpa_pkg::SUM_W-1:0]   column_sum;
  logic [dpa_pkg::SUM_W-1:0]   row_sum_next;
  logic [dpa_pkg::SUM_W-1:0]   column_sum_next;
  logic                        fin_take;
  logic                        fin_valid;
  logic                        fin_bad;
  logic [dpa_pkg::SUM_W-1:0]   fin_row;
  logic [dpa_pkg::SUM_W-1:0]   fin_col;
  logic [dpa_pkg::SUM_W-1:0]   out_row;
  logic [dpa_pkg::SUM_W-1:0]   out_col;

  assign cfg_restart = cfg_write && (cfg_index <= dpa_pkg::REG_EQUAL_WEIGHTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions    <= 2'd1;
      diff_order    <= 3'd1;
      row_count     <= dpa_pkg::LEN_W'(64);
      column_count  <= dpa_pkg::LEN_W'(64);
      equal_weights <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        dpa_pkg::REG_DIMENSIONS:    dimensions    <= cfg_data[1:0];
        dpa_pkg::REG_DIFF_ORDER:    diff_order    <= cfg_data[dpa_pkg::K_W-1:0];
        dpa_pkg::REG_ROW_COUNT:     row_count     <= cfg_data[dpa_pkg::LEN_W-1:0];
        dpa_pkg::REG_COLUMN_COUNT:  column_count  <= cfg_data[dpa_pkg::LEN_W-1:0];
        dpa_pkg::REG_EQUAL_WEIGHTS: equal_weights <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // the pipeline only stops when a finished result has nowhere to go
  assign out_free   = !result_valid || result_ready;
  assign adv        = !(s3_valid && s3_ctrl.last && fin_valid && !out_free);
  assign coef_ready = adv;
  assign in_acc     = coef_valid && adv;

  always_comb begin
    grid     = dimensions == dpa_pkg::DIM_GRID;
    k        = (diff_order > dpa_pkg::K_W'(dpa_pkg::MAX_ORDER)) ?
               dpa_pkg::K_W'(dpa_pkg::MAX_ORDER) : diff_order;
    nr       = dpa_pkg::eff_len(row_count);
    nc       = grid ? dpa_pkg::eff_len(column_count) : dpa_pkg::LEN_W'(1);
    r        = (dpa_pkg::LEN_W'(row_index) >= nr) ? '0 : row_index;
    c        = (dpa_pkg::LEN_W'(column_index) >= nc) ? '0 : column_index;
    row_last = dpa_pkg::LEN_W'(r) == nr - dpa_pkg::LEN_W'(1);
    col_last = dpa_pkg::LEN_W'(c) == nc - dpa_pkg::LEN_W'(1);
    ctrl0.row_ok = dpa_pkg::LEN_W'(r) >= dpa_pkg::LEN_W'(k);
    ctrl0.col_ok = grid && (dpa_pkg::LEN_W'(c) >= dpa_pkg::LEN_W'(k));
    ctrl0.last   = row_last && col_last;
    ctrl0.bad    = (dpa_pkg::LEN_W'(k) > nr - dpa_pkg::LEN_W'(1)) ||
                   (grid && (dpa_pkg::LEN_W'(k) > nc - dpa_pkg::LEN_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index    <= '0;
      column_index <= '0;
      row_taps     <= '0;
    end else if (cfg_restart) begin
      row_index    <= '0;
      column_index <= '0;
      row_taps     <= '0;
    end else if (in_acc) begin
      if (ctrl0.last) begin
        row_index    <= '0;
        column_index <= '0;
        row_taps     <= '0;
      end else begin
        row_taps <= {row_taps[dpa_pkg::MAX_ORDER-2:0], coef_value};
        if (row_last) begin
          row_index    <= '0;
          column_index <= c + dpa_pkg::IDX_W'(1);
        end else begin
          row_index    <= r + dpa_pkg::IDX_W'(1);
          column_index <= c;
        end
      end
    end
  end

  always_comb begin
    store_req.rd_en = in_acc;
    store_req.wr_en = in_acc && grid;
    store_req.bank  = c[dpa_pkg::BANK_W-1:0];
    store_req.addr  = r;
    store_req.data  = coef_value;
  end

  dpa_line_store u_line_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (store_rd)
  );

  // stage 1: input register, store data arrives alongside
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= in_acc;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctrl <= ctrl0;
      s1_k    <= k;
      s1_bank <= c[dpa_pkg::BANK_W-1:0];
      s1_hist <= {row_taps, coef_value};
    end
  end

  // column m back sits in bank (c - m) mod MAX_ORDER
  always_comb begin
    col_hist[0] = s1_hist[0];
    for (int m = 1; m <= dpa_pkg::MAX_ORDER; m++) begin
      col_hist[m] = store_rd[s1_bank - dpa_pkg::BANK_W'(m)];
    end
  end

  // stage 2: difference magnitudes
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (adv) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_ctrl    <= s1_ctrl;
      s2_mag_row <= dpa_pkg::diff_mag(s1_k, s1_hist);
      s2_mag_col <= dpa_pkg::diff_mag(s1_k, col_hist);
    end
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (adv) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      s3_ctrl   <= s2_ctrl;
      s3_sq_row <= s2_mag_row * s2_mag_row;
      s3_sq_col <= s2_mag_col * s2_mag_col;
    end
  end

  // saturating accumulate
  always_comb begin
    row_sum_next    = s3_ctrl.row_ok ?
                      dpa_pkg::sat_add(row_sum, dpa_pkg::SUM_W'(s3_sq_row)) : row_sum;
    column_sum_next = s3_ctrl.col_ok ?
                      dpa_pkg::sat_add(column_sum, dpa_pkg::SUM_W'(s3_sq_col)) : column_sum;
  end

  assign fin_take = adv && s3_valid && s3_ctrl.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum    <= '0;
      column_sum <= '0;
      fin_valid  <= 1'b0;
    end else begin
      if (cfg_restart || fin_take) begin
        row_sum    <= '0;
        column_sum <= '0;
      end else if (adv && s3_valid) begin
        row_sum    <= row_sum_next;
        column_sum <= column_sum_next;
      end
      fin_valid <= fin_take || (fin_valid && !out_free);
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      fin_row <= row_sum_next;
      fin_col <= column_sum_next;
      fin_bad <= s3_ctrl.bad;
    end
  end

  // result register
  always_comb begin
    out_col = grid ? fin_col : '0;
    out_row = (grid && equal_weights) ? dpa_pkg::sat_add(fin_row, out_col) : fin_row;
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (out_free) result_valid <= fin_valid;
  end

  always_ff @(posedge clk) begin
    if (out_free && fin_valid) begin
      status <= fin_bad;
      if (fin_bad) begin
        penalty_rows <= '0;
        penalty_cols <= '0;
      end else begin
        penalty_rows <= $signed(-out_row);
        penalty_cols <= $signed(-out_col);
      end
    end
  end

  `DPA_ASSERT_NOW(a_err_zero, result_valid && status, penalty_rows == '0 && penalty_cols == '0)
  `DPA_ASSERT_NOW(a_rows_nonpos, result_valid, penalty_rows[dpa_pkg::SUM_W-1] || penalty_rows == '0)
  `DPA_ASSERT_NOW(a_row_range, 1'b1, dpa_pkg::LEN_W'(row_index) < nr)
  `DPA_ASSERT_NEXT(a_last_wraps, in_acc && ctrl0.last, row_index == '0 && column_index == '0)

endmodule
